FILE: sv/igdp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fp32 arithmetic functions for the int4 group dot product.
// Depends on nothing; every other file of the block uses it by scoped names.
package igdp_pkg;

  localparam int LANES            = 16;
  localparam int MAX_ROW_LENGTH   = 16384;
  localparam int MAX_GROUP_LENGTH = 256;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int GLEN_W    = 9;
  localparam int RLEN_W    = 15;
  localparam int FP_W      = 32;
  localparam int HF_W      = 16;
  localparam int WQ_W      = 4;
  localparam int ACT_W     = 8;
  localparam int PROD_W    = 12;
  localparam int LSUM_W    = 16;
  localparam int ASUM_W    = 12;
  localparam int DOT_W     = 20;
  localparam int XS_W      = 17;
  localparam int POS_W     = 10;  // chunk index within a row
  localparam int GCH_W     = 5;   // chunks per group, 1..16
  localparam int IG_W      = 4;   // chunk index within a group
  localparam int MOD_CNT_W = 4;

  localparam logic [WQ_W-1:0] NIB_MASK     = 4'hF;
  localparam logic [FP_W-1:0] FP_NEG_EIGHT = 32'hC100_0000;
  localparam logic [FP_W-1:0] FP_QNAN      = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_POS_ZERO  = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_LENGTH = 2'd0,
    CFG_ROW_LENGTH   = 2'd1,
    CFG_ACT_SCALE    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FP_MUL = 1'b0,
    FP_ADD = 1'b1
  } fp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_MERGE,
    ST_SCALE,
    ST_ZERO,
    ST_CMUL,
    ST_TDOT,
    ST_TSUM,
    ST_DIFF,
    ST_ACC,
    ST_WB
  } state_e;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
    logic [GCH_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [IG_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic add;
    logic clear;
  } grp_ctl_t;

  function automatic logic [5:0] lzc49(input logic [48:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd49;
    found = 1'b0;
    for (int i = 48; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(48 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Exact fp16 to fp32 widening.
  function automatic logic [FP_W-1:0] fp16_to_fp32(input logic [HF_W-1:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  p;
    logic [3:0]  k;
    logic [10:0] mn;
    logic [FP_W-1:0] r;
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    k  = 4'd10 - p;
    mn = {1'b0, man} << k;
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'd113 - {4'd0, k}, mn[9:0], 13'd0};
    end else if (ex == 5'h1F) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

  // Exact conversion of a small signed integer.
  function automatic logic [FP_W-1:0] int_to_fp32(input logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0] mag;
    logic [4:0]       p;
    logic [23:0]      m;
    logic [FP_W-1:0]  r;
    mag = v[DOT_W-1] ? (~v + 1'b1) : v;
    p   = 5'd0;
    for (int i = 0; i < DOT_W; i++) begin
      if (mag[i]) p = 5'(i);
    end
    m = {4'd0, mag} << (5'd23 - p);
    if (mag == '0) r = FP_POS_ZERO;
    else r = {v[DOT_W-1], 8'd127 + {3'd0, p}, m[22:0]};
    return r;
  endfunction

  // Round to nearest even and pack. pn has its leading one at bit 47.
  function automatic logic [FP_W-1:0] fp_round_pack(input logic s, input logic signed [11:0] e,
                                                    input logic [47:0] pn, input logic st_in);
    logic signed [11:0] tmp;
    logic [7:0]  sh;
    logic [47:0] sv;
    logic        lost;
    logic [23:0] sig;
    logic        g;
    logic        st;
    logic        up;
    logic [24:0] sig_r;
    logic [7:0]  ee;
    logic [32:0] res;
    logic [FP_W-1:0] r;
    if (e >= 12'sd1) begin
      tmp  = e - 12'sd1;
      ee   = tmp[7:0];
      sv   = pn;
      lost = 1'b0;
    end else begin
      tmp  = 12'sd1 - e;
      sh   = tmp[7:0];
      sv   = pn >> sh;
      lost = |(pn & ~({48{1'b1}} << sh));
      ee   = 8'd0;
    end
    sig   = sv[47:24];
    g     = sv[23];
    st    = (|sv[22:0]) | lost | st_in;
    up    = g & (st | sig[0]);
    sig_r = {1'b0, sig} + {24'd0, up};
    res   = {2'b0, ee, 23'd0} + {8'd0, sig_r};
    if (e >= 12'sd255 || res >= 33'h0_7F80_0000) r = {s, 8'hFF, 23'd0};
    else r = {s, res[30:0]};
    return r;
  endfunction

  function automatic logic [FP_W-1:0] fp_mul(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sr;
    logic [47:0] p;
    logic [48:0] pw;
    logic [5:0]  lz;
    logic signed [11:0] e;
    logic [FP_W-1:0] r;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    sr     = a[31] ^ b[31];
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = ma * mb;
    lz     = lzc49({p, 1'b0});
    pw     = {p, 1'b0} << lz;
    e      = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) r = FP_QNAN;
    else if (a_inf || b_inf) r = {sr, 8'hFF, 23'd0};
    else if (a_zero || b_zero) r = {sr, 31'd0};
    else r = fp_round_pack(sr, e, pw[48:1], 1'b0);
    return r;
  endfunction

  function automatic logic [FP_W-1:0] fp_add(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
    logic [FP_W-1:0] lg;
    logic [FP_W-1:0] sm;
    logic [7:0]  el;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [48:0] xl;
    logic [48:0] xf;
    logic [48:0] xs;
    logic [48:0] s;
    logic [48:0] sn;
    logic [5:0]  lz;
    logic signed [11:0] e;
    logic [FP_W-1:0] r;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    swap   = a[30:0] < b[30:0];
    lg     = swap ? b : a;
    sm     = swap ? a : b;
    el     = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es     = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d      = el - es;
    xl     = {1'b0, lg[30:23] != 8'd0, lg[22:0], 24'd0};
    xf     = {1'b0, sm[30:23] != 8'd0, sm[22:0], 24'd0};
    xs     = xf >> d;
    xs[0]  = xs[0] | (|(xf & ~({49{1'b1}} << d)));
    s      = (a[31] ^ b[31]) ? (xl - xs) : (xl + xs);
    lz     = lzc49(s);
    sn     = s << lz;
    e      = $signed({4'd0, el}) + 12'sd1 - $signed({6'd0, lz});
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) r = FP_QNAN;
    else if (a_inf) r = a;
    else if (b_inf) r = b;
    else if (a_zero && b_zero) r = {a[31] & b[31], 31'd0};
    else if (a_zero) r = b;
    else if (b_zero) r = a;
    else if (s == '0) r = FP_POS_ZERO;
    else r = fp_round_pack(lg[31], e, sn[48:1], sn[0]);
    return r;
  endfunction

endpackage

FILE: sv/igdp_lane.sv
`timescale 1ns / 1ps
// One multiply lane: weight nibble minus eight times an int8 activation.
// Depends on igdp_pkg.
module igdp_lane (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic                                 en_i,
  input  logic [igdp_pkg::WQ_W-1:0]            nibble_i,
  input  logic [igdp_pkg::ACT_W-1:0]           act_i,
  output logic signed [igdp_pkg::PROD_W-1:0]   prod_o,
  output logic signed [igdp_pkg::ACT_W-1:0]    act_o
);

  logic [igdp_pkg::WQ_W-1:0]          q;
  logic signed [igdp_pkg::PROD_W-1:0] wq_ext;
  logic signed [igdp_pkg::PROD_W-1:0] x_ext;
  logic signed [igdp_pkg::PROD_W-1:0] prod_d;
  logic signed [igdp_pkg::PROD_W-1:0] prod_q;
  logic signed [igdp_pkg::ACT_W-1:0]  act_d;
  logic signed [igdp_pkg::ACT_W-1:0]  act_q;

  // q - 8 is the nibble with its top bit flipped, read as signed.
  always_comb begin
    q      = nibble_i & igdp_pkg::NIB_MASK;
    wq_ext = {{(igdp_pkg::PROD_W-igdp_pkg::WQ_W){~q[3]}}, ~q[3], q[2:0]};
    x_ext  = {{(igdp_pkg::PROD_W-igdp_pkg::ACT_W){act_i[7]}}, act_i};
    prod_d = en_i ? (wq_ext * x_ext) : '0;
    act_d  = en_i ? act_i : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      act_q  <= act_d;
    end
  end

  assign prod_o = prod_q;
  assign act_o  = act_q;

endmodule

FILE: sv/igdp_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds the lane results into the group integer accumulators.
// Depends on igdp_pkg.
module igdp_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  igdp_pkg::grp_ctl_t                  ctl_i,
  input  logic signed [igdp_pkg::PROD_W-1:0]  prod_i [igdp_pkg::LANES],
  input  logic signed [igdp_pkg::ACT_W-1:0]   act_i  [igdp_pkg::LANES],
  output logic signed [igdp_pkg::DOT_W-1:0]   dot_o,
  output logic signed [igdp_pkg::XS_W-1:0]    sum_o
);

  logic signed [igdp_pkg::LSUM_W-1:0] psum;
  logic signed [igdp_pkg::ASUM_W-1:0] asum;
  logic signed [igdp_pkg::DOT_W-1:0]  dot_d, dot_q;
  logic signed [igdp_pkg::XS_W-1:0]   sum_d, sum_q;

  always_comb begin
    psum = '0;
    asum = '0;
    for (int i = 0; i < igdp_pkg::LANES; i++) begin
      psum = psum + igdp_pkg::LSUM_W'(prod_i[i]);
      asum = asum + igdp_pkg::ASUM_W'(act_i[i]);
    end
    dot_d = dot_q;
    sum_d = sum_q;
    if (ctl_i.clear) begin
      dot_d = '0;
      sum_d = '0;
    end else if (ctl_i.add) begin
      dot_d = dot_q + igdp_pkg::DOT_W'(psum);
      sum_d = sum_q + igdp_pkg::XS_W'(asum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      sum_q <= '0;
    end else begin
      dot_q <= dot_d;
      sum_q <= sum_d;
    end
  end

  assign dot_o = dot_q;
  assign sum_o = sum_q;

endmodule

FILE: sv/igdp_mod.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle: chunk index mod chunks per group.
// Depends on igdp_pkg.
module igdp_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  igdp_pkg::mod_req_t  req_i,
  output igdp_pkg::mod_rsp_t  rsp_o
);

  logic                              busy_q, busy_d, done_q, done_d;
  logic [igdp_pkg::MOD_CNT_W-1:0]    cnt_q, cnt_d;
  logic [igdp_pkg::POS_W-1:0]        div_q, div_d;
  logic [igdp_pkg::GCH_W-1:0]        dvs_q, dvs_d;
  logic [igdp_pkg::GCH_W-1:0]        rem_q, rem_d;
  logic [igdp_pkg::GCH_W:0]          trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, div_q[igdp_pkg::POS_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = igdp_pkg::MOD_CNT_W'(igdp_pkg::POS_W - 1);
      div_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) trial = trial - {1'b0, dvs_q};
      rem_d = trial[igdp_pkg::GCH_W-1:0];
      div_d = div_q << 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[igdp_pkg::IG_W-1:0];

endmodule

FILE: sv/igdp_fpu.sv
`timescale 1ns / 1ps
// Shared fp32 multiply / add unit, round to nearest even, result registered.
// Depends on igdp_pkg.
module igdp_fpu (
  input  logic                       clk_i,
  input  igdp_pkg::fp_op_e           op_i,
  input  logic [igdp_pkg::FP_W-1:0]  a_i,
  input  logic [igdp_pkg::FP_W-1:0]  b_i,
  output logic [igdp_pkg::FP_W-1:0]  res_o
);

  logic [igdp_pkg::FP_W-1:0] res_d, res_q;

  always_comb begin
    unique case (op_i)
      igdp_pkg::FP_MUL: res_d = igdp_pkg::fp_mul(a_i, b_i);
      igdp_pkg::FP_ADD: res_d = igdp_pkg::fp_add(a_i, b_i);
      default:          res_d = igdp_pkg::FP_QNAN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: sv/int4_group_dot_product.sv
`timescale 1ns / 1ps
// Top level of the W4A8 group-quantized row dot product.
// Depends on igdp_pkg, igdp_lane, igdp_merge, igdp_mod and igdp_fpu.
//
// Each input transaction carries one chunk of 16 elements: sixteen 4-bit weights and
// sixteen int8 activations, plus the fp16 scale and zero point that are latched on the
// first chunk of a group. Sixteen lanes form (q-8)*x side by side, and the merge stage
// adds them into exact integer group sums while input is held.
// A chunk that closes a group runs the group's fp32 update through one shared
// multiply/add unit, seven operations in sequence (scale product, zero minus eight, C,
// A*dot, C*xsum, difference, accumulate) plus a write-back step. A chunk
// that ends the row loads row_value into the output register. While that result waits,
// chunks of the next row still flow; only a chunk that would end the next row is held off
// until the waiting transaction is taken. After a write to group_length the position within
// the group is recomputed by a bit-serial remainder unit, during which input is held.
// Lanes at or past row_length contribute nothing; NaN results come out as 0x7FC00000.
module int4_group_dot_product (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [igdp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [igdp_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [63:0]                     weight_nibbles_i,
  input  logic [63:0]                     act_low_i,
  input  logic [63:0]                     act_high_i,
  input  logic [igdp_pkg::HF_W-1:0]       group_scale_i,
  input  logic [igdp_pkg::HF_W-1:0]       group_zero_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [igdp_pkg::FP_W-1:0]       row_value_o
);

  // Configuration registers.
  logic [igdp_pkg::GLEN_W-1:0] glen_q;
  logic [igdp_pkg::RLEN_W-1:0] rlen_q;
  logic [igdp_pkg::FP_W-1:0]   ascale_q;

  // Row and group position.
  logic [igdp_pkg::POS_W-1:0]  pos_q;
  logic [igdp_pkg::IG_W-1:0]   ig_q;
  logic                        mod_dirty_q;

  logic [igdp_pkg::HF_W-1:0]   scale_q, zero_q;
  logic                        row_end_q, group_end_q;
  logic [igdp_pkg::FP_W-1:0]   acc_q;
  logic [igdp_pkg::FP_W-1:0]   a_q, c_q, t1_q, dotf_q, xsf_q;
  logic                        out_valid_q;
  logic [igdp_pkg::FP_W-1:0]   out_value_q;

  igdp_pkg::state_e state_q, state_d;

  logic [igdp_pkg::GLEN_W-1:0] glen_eff;
  logic [igdp_pkg::GCH_W-1:0]  gch;
  logic [igdp_pkg::RLEN_W-1:0] rlen_eff;
  logic [igdp_pkg::RLEN_W-1:0] pos_el;
  logic [igdp_pkg::LANES-1:0]  lane_en;
  logic                        row_end, group_end, accept;

  logic [8*igdp_pkg::LANES-1:0]             acts;
  logic signed [igdp_pkg::PROD_W-1:0]       lane_prod [igdp_pkg::LANES];
  logic signed [igdp_pkg::ACT_W-1:0]        lane_act  [igdp_pkg::LANES];
  logic signed [igdp_pkg::DOT_W-1:0]        grp_dot;
  logic signed [igdp_pkg::XS_W-1:0]         grp_sum;

  igdp_pkg::grp_ctl_t  grp_ctl;
  igdp_pkg::mod_req_t  mod_req;
  igdp_pkg::mod_rsp_t  mod_rsp;
  igdp_pkg::fp_op_e    fp_op;
  logic [igdp_pkg::FP_W-1:0] fp_a, fp_b, fp_res;

  // Clamp the lengths into range; groups are whole chunks.
  always_comb begin
    glen_eff = glen_q;
    if (glen_q < igdp_pkg::GLEN_W'(igdp_pkg::LANES)) glen_eff = igdp_pkg::GLEN_W'(igdp_pkg::LANES);
    if (glen_q > igdp_pkg::GLEN_W'(igdp_pkg::MAX_GROUP_LENGTH)) begin
      glen_eff = igdp_pkg::GLEN_W'(igdp_pkg::MAX_GROUP_LENGTH);
    end
    gch = glen_eff[igdp_pkg::GLEN_W-1:4];

    rlen_eff = rlen_q;
    if (rlen_q == '0) rlen_eff = igdp_pkg::RLEN_W'(1);
    if (rlen_q > igdp_pkg::RLEN_W'(igdp_pkg::MAX_ROW_LENGTH)) begin
      rlen_eff = igdp_pkg::RLEN_W'(igdp_pkg::MAX_ROW_LENGTH);
    end

    pos_el = {1'b0, pos_q, 4'd0};
    for (int i = 0; i < igdp_pkg::LANES; i++) begin
      lane_en[i] = rlen_eff > (pos_el + igdp_pkg::RLEN_W'(i));
    end
    row_end   = (pos_el + igdp_pkg::RLEN_W'(igdp_pkg::LANES)) >= rlen_eff;
    group_end = row_end || (({1'b0, ig_q} + 1'b1) >= gch);
  end

  assign accept = in_valid_i && !in_stall_o;
  assign acts   = {act_high_i, act_low_i};

  for (genvar g = 0; g < igdp_pkg::LANES; g++) begin : g_lane
    igdp_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (accept),
      .en_i     (lane_en[g]),
      .nibble_i (weight_nibbles_i[4*g +: 4]),
      .act_i    (acts[8*g +: 8]),
      .prod_o   (lane_prod[g]),
      .act_o    (lane_act[g])
    );
  end

  igdp_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (grp_ctl),
    .prod_i (lane_prod),
    .act_i  (lane_act),
    .dot_o  (grp_dot),
    .sum_o  (grp_sum)
  );

  igdp_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  igdp_fpu u_fpu (
    .clk_i (clk_i),
    .op_i  (fp_op),
    .a_i   (fp_a),
    .b_i   (fp_b),
    .res_o (fp_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      igdp_pkg::ST_IDLE: begin
        if (mod_dirty_q) state_d = igdp_pkg::ST_MOD;
        else if (accept) state_d = igdp_pkg::ST_MERGE;
      end
      igdp_pkg::ST_MOD:   if (mod_rsp.done) state_d = igdp_pkg::ST_IDLE;
      igdp_pkg::ST_MERGE: state_d = group_end_q ? igdp_pkg::ST_SCALE : igdp_pkg::ST_IDLE;
      igdp_pkg::ST_SCALE: state_d = igdp_pkg::ST_ZERO;
      igdp_pkg::ST_ZERO:  state_d = igdp_pkg::ST_CMUL;
      igdp_pkg::ST_CMUL:  state_d = igdp_pkg::ST_TDOT;
      igdp_pkg::ST_TDOT:  state_d = igdp_pkg::ST_TSUM;
      igdp_pkg::ST_TSUM:  state_d = igdp_pkg::ST_DIFF;
      igdp_pkg::ST_DIFF:  state_d = igdp_pkg::ST_ACC;
      igdp_pkg::ST_ACC:   state_d = igdp_pkg::ST_WB;
      igdp_pkg::ST_WB:    state_d = igdp_pkg::ST_IDLE;
      default:            state_d = igdp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and the operands of the shared fp unit.
  always_comb begin
    // Stall if busy or recompute is due; a waiting row value holds only row-ending chunks.
    in_stall_o       = !((state_q == igdp_pkg::ST_IDLE) && !mod_dirty_q &&
                         !(out_valid_q && row_end));
    grp_ctl.add      = state_q == igdp_pkg::ST_MERGE;
    grp_ctl.clear    = state_q == igdp_pkg::ST_WB;
    mod_req.start    = (state_q == igdp_pkg::ST_IDLE) && mod_dirty_q;
    mod_req.dividend = pos_q;
    mod_req.divisor  = gch;
    fp_op = igdp_pkg::FP_MUL;
    fp_a  = '0;
    fp_b  = '0;
    unique case (state_q)
      igdp_pkg::ST_SCALE: begin
        fp_a = igdp_pkg::fp16_to_fp32(scale_q);
        fp_b = ascale_q;
      end
      igdp_pkg::ST_ZERO: begin
        fp_op = igdp_pkg::FP_ADD;
        fp_a  = igdp_pkg::fp16_to_fp32(zero_q);
        fp_b  = igdp_pkg::FP_NEG_EIGHT;
      end
      igdp_pkg::ST_CMUL: begin
        fp_a = a_q;
        fp_b = fp_res;
      end
      igdp_pkg::ST_TDOT: begin
        fp_a = a_q;
        fp_b = dotf_q;
      end
      igdp_pkg::ST_TSUM: begin
        fp_a = c_q;
        fp_b = xsf_q;
      end
      igdp_pkg::ST_DIFF: begin
        // subtract by flipping the sign of the subtrahend
        fp_op = igdp_pkg::FP_ADD;
        fp_a  = t1_q;
        fp_b  = {~fp_res[31], fp_res[30:0]};
      end
      igdp_pkg::ST_ACC: begin
        fp_op = igdp_pkg::FP_ADD;
        fp_a  = acc_q;
        fp_b  = fp_res;
      end
      default: begin
        fp_op = igdp_pkg::FP_MUL;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= igdp_pkg::ST_IDLE;
      glen_q      <= igdp_pkg::GLEN_W'(64);
      rlen_q      <= igdp_pkg::RLEN_W'(igdp_pkg::MAX_ROW_LENGTH);
      ascale_q    <= 32'h3F80_0000;
      pos_q       <= '0;
      ig_q        <= '0;
      mod_dirty_q <= 1'b0;
      scale_q     <= '0;
      zero_q      <= '0;
      row_end_q   <= 1'b0;
      group_end_q <= 1'b0;
      acc_q       <= igdp_pkg::FP_POS_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Set the recompute flag on a group length write; clear it on start.
      if (cfg_we_i && (cfg_index_i == igdp_pkg::CFG_GROUP_LENGTH)) mod_dirty_q <= 1'b1;
      else if (mod_req.start) mod_dirty_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          igdp_pkg::CFG_GROUP_LENGTH: glen_q   <= cfg_data_i[igdp_pkg::GLEN_W-1:0];
          igdp_pkg::CFG_ROW_LENGTH:   rlen_q   <= cfg_data_i[igdp_pkg::RLEN_W-1:0];
          igdp_pkg::CFG_ACT_SCALE:    ascale_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (mod_rsp.done) ig_q <= mod_rsp.rem;

      if (accept) begin
        if (ig_q == '0) begin
          scale_q <= group_scale_i;
          zero_q  <= group_zero_i;
        end
        row_end_q   <= row_end;
        group_end_q <= group_end;
        if (row_end) begin
          pos_q <= '0;
          ig_q  <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
          ig_q  <= group_end ? '0 : (ig_q + 1'b1);
        end
      end

      // Load a new result at the end of a row; drop the result once taken.
      if ((state_q == igdp_pkg::ST_WB) && row_end_q) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (state_q == igdp_pkg::ST_WB) begin
        if (row_end_q) acc_q <= igdp_pkg::FP_POS_ZERO;
        else acc_q <= fp_res;
      end
    end
  end

  // Intermediate fp values.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      igdp_pkg::ST_SCALE: begin
        dotf_q <= igdp_pkg::int_to_fp32(grp_dot);
        xsf_q  <= igdp_pkg::int_to_fp32(igdp_pkg::DOT_W'(grp_sum));
      end
      igdp_pkg::ST_ZERO: a_q  <= fp_res;
      igdp_pkg::ST_TDOT: c_q  <= fp_res;
      igdp_pkg::ST_TSUM: t1_q <= fp_res;
      igdp_pkg::ST_WB: begin
        if (row_end_q) begin
          if ((fp_res[30:23] == 8'hFF) && (fp_res[22:0] != '0)) out_value_q <= igdp_pkg::FP_QNAN;
          else out_value_q <= fp_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign row_value_o = out_value_q;

  a_accept_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == igdp_pkg::ST_MERGE)
    else $error("accepted chunk did not go to the merge stage");

  a_row_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == igdp_pkg::ST_WB) && row_end_q |=> out_valid_q)
    else $error("row end did not produce a result");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (acc_q == igdp_pkg::FP_POS_ZERO) && (pos_q == '0))
    else $error("row state not cleared with the result");

  a_mod_owns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.busy |-> state_q == igdp_pkg::ST_MOD)
    else $error("remainder unit busy outside its state");

  a_ig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == igdp_pkg::ST_IDLE) && !mod_dirty_q |-> ({1'b0, ig_q} < gch))
    else $error("group chunk index out of range");

endmodule
